@@ rtl/lspb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types for the LED strip pixel buffer.
// Depends on nothing; lspb_locate and led_strip_pixel_buffer import it.
package lspb_pkg;

    // Geometry of the buffer
    localparam int NUM_STRIPS     = 8;
    localparam int LEDS_PER_STRIP = 1024;
    localparam int MEM_WORDS      = NUM_STRIPS * LEDS_PER_STRIP;
    localparam int ADDR_W         = $clog2(MEM_WORDS);
    localparam int STRIP_W        = (NUM_STRIPS > 1) ? $clog2(NUM_STRIPS) : 1;
    localparam int LEN_W          = $clog2(LEDS_PER_STRIP + 1);

    // Field widths
    localparam int ACT_W   = 2;
    localparam int IDX_W   = 13;
    localparam int RUN_W   = 11;
    localparam int COLOR_W = 24;
    localparam int SEL_W   = 4;
    localparam int REQ_W   = 16;
    localparam int SEG_W   = 11;
    localparam int SUM_W   = SEG_W + 1;
    localparam int AW_EXT  = ((ADDR_W > SEG_W) ? ADDR_W : SEG_W) + 1;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_SEGMENT_LEN = 1'b0;
    localparam logic [SEG_W-1:0] SEG_RESET = 11'd1024;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_FILL  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SETLEN = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCATE,
        S_FILL,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

    // Result of splitting a global index into strip and offset
    typedef struct packed {
        logic               done;
        logic               ok;
        logic [STRIP_W-1:0] strip;
        logic [SEG_W-1:0]   offset;
        logic [ADDR_W-1:0]  base;
    } loc_t;

endpackage

@@ rtl/lspb_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module lspb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one word per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lspb_locate.sv @@
`timescale 1ns / 1ps
// Iterative index splitter: one subtraction of the segment length per cycle.
// Depends on lspb_pkg.
module lspb_locate
    import lspb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IDX_W-1:0] index,
    input  logic [SEG_W-1:0] seg_len,
    output loc_t             loc
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [IDX_W-1:0]   rem_reg, rem_next;
    logic [STRIP_W-1:0] strip_reg, strip_next;
    logic [ADDR_W-1:0]  base_reg, base_next;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working values
    always_ff @(posedge aclk) begin
        ok_reg    <= ok_next;
        rem_reg   <= rem_next;
        strip_reg <= strip_next;
        base_reg  <= base_next;
    end

    // Subtract one segment per cycle until the remainder fits
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        rem_next   = rem_reg;
        strip_next = strip_reg;
        base_next  = base_reg;
        if (start) begin
            busy_next  = 1'b1;
            rem_next   = index;
            strip_next = '0;
            base_next  = '0;
        end else if (busy_reg) begin
            if (seg_len == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b0;
            end else if (rem_reg < IDX_W'(seg_len)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b1;
            end else if (strip_reg == STRIP_W'(NUM_STRIPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b0;
            end else begin
                rem_next   = rem_reg - IDX_W'(seg_len);
                strip_next = strip_reg + STRIP_W'(1);
                base_next  = base_reg + ADDR_W'(LEDS_PER_STRIP);
            end
        end
    end

    assign loc.done   = done_reg;
    assign loc.ok     = ok_reg;
    assign loc.strip  = strip_reg;
    assign loc.offset = rem_reg[SEG_W-1:0];
    assign loc.base   = base_reg;

endmodule

@@ rtl/led_strip_pixel_buffer.sv @@
`timescale 1ns / 1ps
// Top level of the LED strip pixel buffer: controller, strip lengths, APB register.
// Depends on lspb_pkg, lspb_ram and lspb_locate.
//
// Frame buffer for NUM_STRIPS strips of up to LEDS_PER_STRIP 24-bit pixels, held in
// one single-port RAM. Each input transaction carries one action and yields exactly
// one result transaction. After reset the block runs a clearing pass over all MEM_WORDS
// pixels (8192 here), one pixel a cycle, with s_ready low; clear all runs the same
// pass and then returns its result. A global index is split into strip and offset by
// an iterative unit that subtracts segment_len once per cycle; a fill is then bounded
// by the one RAM port that writes one pixel a cycle. One action is worked at a time;
// a finished result waits in the output register while the next transaction is
// accepted. segment_len is written through the APB port at address 0.
module led_strip_pixel_buffer
    import lspb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ACT_W-1:0]   s_action,
    input  logic [IDX_W-1:0]   s_pixel_index,
    input  logic [RUN_W-1:0]   s_run_length,
    input  logic [COLOR_W-1:0] s_color,
    input  logic [SEL_W-1:0]   s_strip_select,
    input  logic [REQ_W-1:0]   s_strip_length,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_read_color,
    output logic               m_status,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    state_t state_reg, state_next;

    logic [SEG_W-1:0]   segment_len_reg;
    logic [LEN_W-1:0]   strip_len_reg [NUM_STRIPS];

    logic [ACT_W-1:0]   action_reg, action_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [RUN_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic               clr_resp_reg, clr_resp_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    logic               res_status_reg, res_status_next;

    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] m_read_color_reg, m_read_color_next;
    logic               m_status_reg, m_status_next;

    logic               len_we;
    logic [STRIP_W-1:0] len_idx;
    logic [LEN_W-1:0]   len_wdata;

    logic               loc_start;
    loc_t               loc;
    logic [LEN_W-1:0]   cur_len;
    logic [SUM_W-1:0]   fill_end;
    logic [ADDR_W-1:0]  loc_addr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;

    logic               in_accept;
    logic               out_free;
    logic               cfg_write;

    // Pixel store
    lspb_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(MEM_WORDS)
    ) u_pixel_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Index to strip and offset
    lspb_locate u_locate (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (loc_start),
        .index  (s_pixel_index),
        .seg_len(segment_len_reg),
        .loc    (loc)
    );

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign loc_start = in_accept
                       && (s_action == ACT_FILL || s_action == ACT_READ);

    // Strip length and pixel address for the located strip
    assign cur_len  = strip_len_reg[loc.strip];
    assign fill_end = SUM_W'(loc.offset) + SUM_W'(run_reg);
    assign loc_addr = ADDR_W'(AW_EXT'(loc.base) + AW_EXT'(loc.offset));

    // Configuration register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_SEGMENT_LEN)
                       ? PDATA_W'(segment_len_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_len_reg <= SEG_RESET;
        end else if (cfg_write && paddr[PADDR_W-1:2] == REG_SEGMENT_LEN) begin
            segment_len_reg <= pwdata[SEG_W-1:0];
        end
    end

    // Strip lengths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STRIPS; i++) begin
                strip_len_reg[i] <= LEN_W'(LEDS_PER_STRIP);
            end
        end else if (len_we) begin
            strip_len_reg[len_idx] <= len_wdata;
        end
    end

    // Clamp a requested strip length
    always_comb begin
        len_idx = s_strip_select[STRIP_W-1:0];
        if (s_strip_length >= REQ_W'(LEDS_PER_STRIP)) begin
            len_wdata = LEN_W'(LEDS_PER_STRIP - 1);
        end else if (s_strip_length == '0) begin
            len_wdata = LEN_W'(1);
        end else begin
            len_wdata = s_strip_length[LEN_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working values and payload; the clear pass starts at word zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else begin
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg       <= action_next;
        run_reg          <= run_next;
        color_reg        <= color_next;
        fill_cnt_reg     <= fill_cnt_next;
        res_color_reg    <= res_color_next;
        res_status_reg   <= res_status_next;
        m_read_color_reg <= m_read_color_next;
        m_status_reg     <= m_status_next;
    end

    // Next state, memory access and result
    always_comb begin
        state_next        = state_reg;
        action_next       = action_reg;
        run_next          = run_reg;
        color_next        = color_reg;
        addr_next         = addr_reg;
        fill_cnt_next     = fill_cnt_reg;
        clr_resp_next     = clr_resp_reg;
        res_color_next    = res_color_reg;
        res_status_next   = res_status_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_color_next = m_read_color_reg;
        m_status_next     = m_status_reg;
        len_we            = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = addr_reg;
        ram_wdata         = color_reg;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(MEM_WORDS - 1)) begin
                    addr_next       = '0;
                    res_color_next  = '0;
                    res_status_next = 1'b0;
                    state_next      = clr_resp_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    action_next = s_action;
                    run_next    = s_run_length;
                    color_next  = s_color;
                    unique case (s_action)
                        ACT_FILL, ACT_READ: begin
                            state_next = S_LOCATE;
                        end
                        ACT_SETLEN: begin
                            len_we          = ({1'b0, s_strip_select} < (SEL_W + 1)'(NUM_STRIPS));
                            res_color_next  = '0;
                            res_status_next = !len_we;
                            state_next      = S_DONE;
                        end
                        ACT_CLEAR: begin
                            addr_next     = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOCATE: begin
                if (loc.done) begin
                    res_color_next  = '0;
                    res_status_next = 1'b0;
                    state_next      = S_DONE;
                    if (!loc.ok) begin
                        res_status_next = 1'b1;
                    end else if (action_reg == ACT_FILL) begin
                        // Reject the whole run if it passes the strip end
                        if (fill_end > SUM_W'(cur_len)) begin
                            res_status_next = 1'b1;
                        end else if (run_reg != '0) begin
                            addr_next     = loc_addr;
                            fill_cnt_next = run_reg;
                            state_next    = S_FILL;
                        end
                    end else if (SUM_W'(loc.offset) < SUM_W'(cur_len)) begin
                        addr_next  = loc_addr;
                        state_next = S_READ;
                    end
                end
            end
            S_FILL: begin
                ram_we        = 1'b1;
                addr_next     = addr_reg + ADDR_W'(1);
                fill_cnt_next = fill_cnt_reg - RUN_W'(1);
                if (fill_cnt_reg == RUN_W'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                res_color_next = ram_rdata;
                state_next     = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_read_color_next = res_color_reg;
                    m_status_next     = res_status_reg;
                    clr_resp_next     = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_read_color = m_read_color_reg;
    assign m_status     = m_status_reg;

    // A rejected action never carries a colour
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_status_reg) |-> (res_color_reg == '0))
        else $error("rejected result carries a colour");

    // Memory writes stay inside the pixel store
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_addr <= ADDR_W'(MEM_WORDS - 1)))
        else $error("pixel write beyond memory");

    // The splitter reports only while the controller waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        loc.done |-> (state_reg == S_LOCATE))
        else $error("locate result outside locate state");

    // A fill in progress always has pixels left to write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (fill_cnt_reg != '0))
        else $error("fill running with empty count");

    // A result is handed over only when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output register full");

endmodule
